// File: sv/akc_pkg.sv
// Shared types, character codes and helper functions for the autokey letter cipher.
`default_nettype none

package akc_pkg;

   typedef enum logic [1:0] {
      ACT_LOAD_KEY = 2'd0,
      ACT_ENCIPHER = 2'd1,
      ACT_CLEAR    = 2'd2,
      ACT_NOP      = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  in_char;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        was_ciphered;
      logic        key_overflow;
   } rsp_type;

   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [5:0] ALPHABET_LEN = 6'd26;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
   endfunction

   function automatic logic [4:0] letter_index(input logic [7:0] c);
      logic [7:0] diff;
      diff = is_upper(c) ? (c - CHAR_UPPER_A) : (c - CHAR_LOWER_A);
      return diff[4:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/akc_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module akc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // A read and a write to the same entry in one cycle return the old contents.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/autokey_letter_cipher.sv
// Autokey letter cipher over a byte stream with the key ring held in a memory.
//
// The req channel carries one action and one byte per transfer: load a key
// byte, encipher a message byte, or clear the key ring. Every request gives
// exactly one transfer on the rsp channel, in order. Key bytes other than
// space are queued in a ring of KEY_MAX entries; each non-space message byte
// pops the oldest key byte and pushes itself if the ring is not empty (else it
// keys itself), so the keystream continues with the message text. Letter pairs
// are added modulo 26 in the message's case; all other bytes pass unchanged.
// A request is accepted in the cycle it is offered if the pipeline has room.
// The ring memory is read in the accept cycle, beside the stage-one registers,
// and the result is registered again in the response register. Throughput is
// one transfer per cycle while rsp_stall is low: ring head and count live in
// flops and the ring has one write and one read port used once per request.
// While rsp_stall is high the response holds, and req_stall rises once the
// one request in flight behind it is also waiting. Reset empties the ring and
// drops any request in flight; no clearing pass over the memory is needed.
`default_nettype none

module autokey_letter_cipher #(
   parameter int KEY_MAX = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire akc_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      akc_pkg::rsp_type rsp_data
);

   localparam int AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int CW = $clog2(KEY_MAX + 1);

   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 accept;
   logic                 not_space;
   logic                 ring_full;
   logic                 ring_empty;
   logic [CW:0]          slot_sum;
   logic [AW-1:0]        tail_addr;
   logic [AW-1:0]        head_next;
   logic                 wr_en;
   logic                 rd_en;
   logic                 use_ram;
   logic                 overflow;
   logic [7:0]           rd_data;

   logic                 s1_valid_ff;
   akc_pkg::action_type  s1_act_ff;
   logic [7:0]           s1_char_ff;
   logic                 s1_use_ram_ff;
   logic                 s1_ovf_ff;
   logic                 s1_advance;

   logic                 rsp_valid_ff;
   akc_pkg::rsp_type     rsp_data_ff;
   akc_pkg::rsp_type     rsp_data_in;

   logic [7:0]           key_char;
   logic [5:0]           letter_sum;
   logic [4:0]           letter_mod;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;

   assign not_space  = (req_data.in_char != akc_pkg::CHAR_SPACE);
   assign ring_full  = (count_ff == CW'(KEY_MAX));
   assign ring_empty = (count_ff == '0);

   always_comb begin
      slot_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
      if (slot_sum >= (CW + 1)'(KEY_MAX)) begin
         slot_sum = slot_sum - (CW + 1)'(KEY_MAX);
      end
      tail_addr = AW'(slot_sum);
      head_next = (head_ff == AW'(KEY_MAX - 1)) ? '0 : head_ff + AW'(1);
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      use_ram  = 1'b0;
      overflow = 1'b0;
      case (req_data.action)
         akc_pkg::ACT_LOAD_KEY: begin
            if (not_space) begin
               if (ring_full) begin
                  overflow = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         akc_pkg::ACT_ENCIPHER: begin
            if (not_space && !ring_empty) begin
               wr_en   = 1'b1;
               use_ram = 1'b1;
               head_in = head_next;
            end
         end
         akc_pkg::ACT_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign rd_en = accept && use_ram;

   akc_ram #(
      .WIDTH (8),
      .DEPTH (KEY_MAX)
   ) u_key_ring (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (tail_addr),
      .wr_data (req_data.in_char),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      key_char   = s1_use_ram_ff ? rd_data : s1_char_ff;
      letter_sum = 6'(akc_pkg::letter_index(s1_char_ff)) + 6'(akc_pkg::letter_index(key_char));
      if (letter_sum >= akc_pkg::ALPHABET_LEN) begin
         letter_sum = letter_sum - akc_pkg::ALPHABET_LEN;
      end
      letter_mod = letter_sum[4:0];

      rsp_data_in.out_char     = s1_char_ff;
      rsp_data_in.was_ciphered = 1'b0;
      rsp_data_in.key_overflow = s1_ovf_ff;
      if ((s1_act_ff == akc_pkg::ACT_ENCIPHER) &&
          (s1_char_ff != akc_pkg::CHAR_SPACE) &&
          (akc_pkg::is_upper(s1_char_ff) || akc_pkg::is_lower(s1_char_ff)) &&
          (akc_pkg::is_upper(key_char) || akc_pkg::is_lower(key_char))) begin
         rsp_data_in.was_ciphered = 1'b1;
         rsp_data_in.out_char     = (akc_pkg::is_upper(s1_char_ff) ?
                                     akc_pkg::CHAR_UPPER_A : akc_pkg::CHAR_LOWER_A)
                                    + 8'(letter_mod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff     <= req_data.action;
         s1_char_ff    <= req_data.in_char;
         s1_use_ram_ff <= use_ram;
         s1_ovf_ff     <= overflow;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: test/tb_autokey_letter_cipher.sv
// Self-checking testbench for the autokey letter cipher with an in-bench keystream predictor.
module tb_autokey_letter_cipher;

   localparam int KEY_MAX          = 16;
   localparam int RANDOM_PER_PHASE = 120;
   localparam int LONG_HOLD        = 300;
   localparam int IDLE_LIMIT       = 3000;
   localparam int DRAIN_CYCLES     = 8;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   akc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   akc_pkg::rsp_type rsp_data;

   akc_pkg::req_type pending_req[$];
   akc_pkg::rsp_type expected_rsp[$];
   int      queued_items   = 0;
   int      accepted_items = 0;
   int      err_count      = 0;
   int      sender_idle_pct = 0;
   int      recv_stall_pct  = 0;
   int      idle_cycles     = 0;
   int      hold_left       = 0;
   logic    long_hold_arm   = 1'b0;
   logic    long_hold_done  = 1'b0;

   logic [7:0] key_ring [KEY_MAX];
   logic [3:0] ring_head  = '0;
   logic [4:0] ring_count = '0;

   autokey_letter_cipher #(
      .KEY_MAX(KEY_MAX)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int letter_base(input logic [7:0] c);
      if (c >= akc_pkg::CHAR_UPPER_A && c <= akc_pkg::CHAR_UPPER_Z) begin
         return int'(akc_pkg::CHAR_UPPER_A);
      end else if (c >= akc_pkg::CHAR_LOWER_A && c <= akc_pkg::CHAR_LOWER_Z) begin
         return int'(akc_pkg::CHAR_LOWER_A);
      end
      return 0;
   endfunction

   function automatic akc_pkg::rsp_type autokey_encipher(input akc_pkg::req_type item);
      akc_pkg::rsp_type r;
      logic [7:0]       c;
      logic [7:0]       k;
      logic [3:0]       slot;
      int               mbase;
      int               kbase;
      c = item.in_char;
      r.out_char     = c;
      r.was_ciphered = 1'b0;
      r.key_overflow = 1'b0;
      slot = ring_head + ring_count[3:0];
      case (item.action)
         akc_pkg::ACT_LOAD_KEY: begin
            if (c != akc_pkg::CHAR_SPACE) begin
               if (ring_count >= KEY_MAX) begin
                  r.key_overflow = 1'b1;
               end else begin
                  key_ring[slot] = c;
                  ring_count = ring_count + 5'd1;
               end
            end
         end
         akc_pkg::ACT_ENCIPHER: begin
            if (c != akc_pkg::CHAR_SPACE) begin
               if (ring_count == 0) begin
                  k = c;
               end else begin
                  k = key_ring[ring_head];
                  key_ring[slot] = c;
                  ring_head = ring_head + 4'd1;
               end
               mbase = letter_base(c);
               kbase = letter_base(k);
               if (mbase != 0 && kbase != 0) begin
                  r.out_char = 8'(mbase + ((int'(c) - mbase) + (int'(k) - kbase))
                                          % int'(akc_pkg::ALPHABET_LEN));
                  r.was_ciphered = 1'b1;
               end
            end
         end
         akc_pkg::ACT_CLEAR: begin
            ring_count = '0;
            ring_head  = '0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic logic [7:0] key_char();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 8'(int'(akc_pkg::CHAR_UPPER_A) + $urandom_range(25));
      if (r < 85) return 8'(int'(akc_pkg::CHAR_LOWER_A) + $urandom_range(25));
      if (r < 92) return akc_pkg::CHAR_SPACE;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] text_char();
      int r;
      r = $urandom_range(99);
      if (r < 30) return 8'(int'(akc_pkg::CHAR_UPPER_A) + $urandom_range(25));
      if (r < 60) return 8'(int'(akc_pkg::CHAR_LOWER_A) + $urandom_range(25));
      if (r < 75) return akc_pkg::CHAR_SPACE;
      return 8'($urandom_range(255));
   endfunction

   task automatic queue_item(input akc_pkg::action_type a, input logic [7:0] c);
      akc_pkg::req_type item;
      item.action  = a;
      item.in_char = c;
      pending_req.push_back(item);
      queued_items++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(autokey_encipher(req_data));
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data  <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_arm && !long_hold_done) begin
         rsp_stall      <= 1'b1;
         hold_left      <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      akc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("response transfer with no request outstanding: %0h", rsp_data);
            err_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.out_char !== want.out_char) begin
               $error("out_char: expected %0h, got %0h", want.out_char, rsp_data.out_char);
               err_count++;
            end
            if (rsp_data.was_ciphered !== want.was_ciphered) begin
               $error("was_ciphered: expected %0b, got %0b",
                      want.was_ciphered, rsp_data.was_ciphered);
               err_count++;
            end
            if (rsp_data.key_overflow !== want.key_overflow) begin
               $error("key_overflow: expected %0b, got %0b",
                      want.key_overflow, rsp_data.key_overflow);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int ph;
      int i;
      int len;
      int start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 0;
            end
            1: begin
               sender_idle_pct = 55;
               recv_stall_pct  = 0;
            end
            2: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 55;
            end
            default: begin
               sender_idle_pct = 20;
               recv_stall_pct  = 20;
            end
         endcase
         if (ph == 0) begin
            // Empty ring: message bytes key themselves, spaces pass through; a loaded "Z" then keys "z".
            queue_item(akc_pkg::ACT_NOP, 8'hFF);
            queue_item(akc_pkg::ACT_ENCIPHER, "q");
            queue_item(akc_pkg::ACT_ENCIPHER, akc_pkg::CHAR_SPACE);
            queue_item(akc_pkg::ACT_LOAD_KEY, akc_pkg::CHAR_SPACE);
            queue_item(akc_pkg::ACT_LOAD_KEY, "Z");
            queue_item(akc_pkg::ACT_ENCIPHER, "z");
            queue_item(akc_pkg::ACT_ENCIPHER, 8'h00);
            queue_item(akc_pkg::ACT_CLEAR, 8'h00);
            // Fill the ring, overflow it, then encipher with a full ring.
            for (i = 0; i < KEY_MAX; i++) begin
               queue_item(akc_pkg::ACT_LOAD_KEY,
                          (i % 2 == 1) ? 8'(int'(akc_pkg::CHAR_LOWER_A) + i)
                                       : 8'(int'(akc_pkg::CHAR_UPPER_A) + i));
            end
            queue_item(akc_pkg::ACT_LOAD_KEY, 8'hFF);
            queue_item(akc_pkg::ACT_ENCIPHER, "M");
         end
         start = queued_items;
         while (queued_items - start < RANDOM_PER_PHASE) begin
            if ($urandom_range(99) < 80) begin
               if ($urandom_range(99) < 70) begin
                  queue_item(akc_pkg::ACT_CLEAR, 8'($urandom_range(255)));
               end
               len = $urandom_range(20, 1);
               for (i = 0; i < len; i++) begin
                  queue_item(akc_pkg::ACT_LOAD_KEY, key_char());
               end
               len = $urandom_range(24, 1);
               for (i = 0; i < len; i++) begin
                  queue_item(akc_pkg::ACT_ENCIPHER, text_char());
               end
            end else begin
               len = $urandom_range(6, 1);
               for (i = 0; i < len; i++) begin
                  queue_item(akc_pkg::action_type'(2'($urandom_range(3))),
                             8'($urandom_range(255)));
               end
            end
         end
         if (ph == 0) begin
            long_hold_arm = 1'b1;
         end
         while (accepted_items != queued_items || expected_rsp.size() != 0) begin
            @(posedge clock);
         end
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d expected responses never arrived", expected_rsp.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/akc_pkg.sv
sv/akc_ram.sv
sv/autokey_letter_cipher.sv
test/tb_autokey_letter_cipher.sv
